// ===== rtl/core/mcat_pkg.sv =====
// Package for the multi-channel compare alarm timer.
// Holds field widths, command codes and the per-channel control struct.
// No dependencies.
`timescale 1ns / 1ps

package mcat_pkg;

  localparam int COUNT_W = 16;
  localparam int CMD_W   = 3;
  localparam int CHAN_W  = 3;
  localparam int MASK_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_ARM_NOW = 3'd1,
    CMD_ARM_REF = 3'd2,
    CMD_UNSET   = 3'd3,
    CMD_STOP    = 3'd4,
    CMD_START   = 3'd5
  } cmd_t;

  // Decoded command, broadcast to every compare channel
  typedef struct packed {
    logic               tick_en;
    logic               arm;
    logic               unset;
    logic               stop;
    logic               start;
    logic [COUNT_W-1:0] arm_value;
    logic [COUNT_W-1:0] arm_period;
  } chan_ctrl_t;

endpackage

// ===== rtl/core/mcat_if.sv =====
// Valid/ready channel interfaces for the compare alarm timer.
// Depends on mcat_pkg for field widths.
`timescale 1ns / 1ps

interface mcat_in_if;
  import mcat_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [CHAN_W-1:0]  channel;
  logic [COUNT_W-1:0] delay_ticks;
  logic [COUNT_W-1:0] repeat_period;
  logic [COUNT_W-1:0] reference_time;

  modport source(output valid, command, channel, delay_ticks, repeat_period,
                 reference_time, input ready);
  modport sink(input valid, command, channel, delay_ticks, repeat_period,
               reference_time, output ready);
endinterface

interface mcat_out_if;
  import mcat_pkg::*;

  logic               valid;
  logic               ready;
  logic               accepted;
  logic [MASK_W-1:0]  fired_mask;
  logic [COUNT_W-1:0] current_count;

  modport source(output valid, accepted, fired_mask, current_count, input ready);
  modport sink(input valid, accepted, fired_mask, current_count, output ready);
endinterface

// ===== rtl/core/mcat_chan.sv =====
// One compare channel: compare value, reload period and enable.
// Depends on mcat_pkg for the control struct.
`timescale 1ns / 1ps

module mcat_chan (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic                            sel,
  input  mcat_pkg::chan_ctrl_t            ctrl,
  input  logic [mcat_pkg::COUNT_W-1:0]    new_count,
  output logic                            fired
);
  import mcat_pkg::*;

  logic [COUNT_W-1:0] compare;
  logic [COUNT_W-1:0] period;
  logic               enabled;

  assign fired = ctrl.tick_en && enabled && (compare == new_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      compare <= '0;
      period  <= '0;
      enabled <= 1'b0;
    end else if (step) begin
      if (fired) begin
        // reload on a nonzero period, otherwise retire the one-shot
        if (period != '0) begin
          compare <= compare + period;
        end else begin
          compare <= '0;
          enabled <= 1'b0;
        end
      end
      if (ctrl.arm && sel) begin
        compare <= ctrl.arm_value;
        period  <= ctrl.arm_period;
        enabled <= 1'b1;
      end
      if (ctrl.unset && sel) begin
        compare <= '0;
        period  <= '0;
        enabled <= 1'b0;
      end
      if (ctrl.stop) begin
        enabled <= 1'b0;
      end
      if (ctrl.start) begin
        period  <= '0;
        enabled <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/multi_channel_compare_alarm_timer.sv =====
// Top level of the multi-channel compare alarm timer.
// Depends on mcat_pkg, mcat_in_if / mcat_out_if and mcat_chan.
`timescale 1ns / 1ps

// A 16-bit tick counter with CHANNELS compare channels (1 to 8). Each command
// transfer yields exactly one result transfer: accepted, the mask of channels
// that fired (channels 0 to 2 only) and the count after the command. A new
// command can be taken every clock cycle while the sink does not stall; a
// command passes the input register and then the result register. The
// result register lets a command be taken while the previous result still
// waits on a stalled sink. Arm and unset with a channel at or above CHANNELS,
// and undefined command codes, change nothing and report accepted low.
module multi_channel_compare_alarm_timer #(
  parameter int CHANNELS = 3
) (
  input  logic       clk,
  input  logic       rst,
  mcat_in_if.sink    req,
  mcat_out_if.source rsp
);
  import mcat_pkg::*;

  // Input register
  logic               in_valid;
  logic [CMD_W-1:0]   in_command;
  logic [CHAN_W-1:0]  in_channel;
  logic [COUNT_W-1:0] in_delay;
  logic [COUNT_W-1:0] in_period;
  logic [COUNT_W-1:0] in_reference;

  // Timer state
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               counting;
  logic               counting_next;

  // Result register
  logic               out_valid;
  logic               out_accepted;
  logic [MASK_W-1:0]  out_fired;
  logic [COUNT_W-1:0] out_count;

  logic               out_free;
  logic               step;
  logic               ch_ok;
  logic               accepted_next;
  chan_ctrl_t         ctrl;
  logic [CHANNELS-1:0] fired;
  logic [MASK_W-1:0]  fired_mask;

  // Advance the stored command whenever the result register can take it
  assign out_free  = !out_valid || rsp.ready;
  assign step      = in_valid && out_free;
  assign req.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_command   <= req.command;
      in_channel   <= req.channel;
      in_delay     <= req.delay_ticks;
      in_period    <= req.repeat_period;
      in_reference <= req.reference_time;
    end
  end

  assign ch_ok = {1'b0, in_channel} < (CHAN_W + 1)'(CHANNELS);

  // Decode the command into the shared channel controls
  always_comb begin
    ctrl            = '0;
    ctrl.arm_period = in_period;
    ctrl.arm_value  = count + in_delay;
    accepted_next   = 1'b1;
    count_next      = count;
    counting_next   = counting;
    case (cmd_t'(in_command))
      CMD_TICK: begin
        if (counting) begin
          count_next   = count + 1'b1;
          ctrl.tick_en = 1'b1;
        end
      end
      CMD_ARM_NOW: begin
        ctrl.arm      = ch_ok;
        accepted_next = ch_ok;
      end
      CMD_ARM_REF: begin
        ctrl.arm       = ch_ok;
        ctrl.arm_value = in_reference + in_delay;
        accepted_next  = ch_ok;
      end
      CMD_UNSET: begin
        ctrl.unset    = ch_ok;
        accepted_next = ch_ok;
      end
      CMD_STOP: begin
        ctrl.stop     = 1'b1;
        counting_next = 1'b0;
      end
      CMD_START: begin
        ctrl.start    = 1'b1;
        counting_next = 1'b1;
      end
      default: begin
        accepted_next = 1'b0;
      end
    endcase
  end

  // One compare unit per channel, all checked against the new count at once
  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    mcat_chan u_chan (
      .clk       (clk),
      .rst       (rst),
      .step      (step),
      .sel       (in_channel == CHAN_W'(c)),
      .ctrl      (ctrl),
      .new_count (count_next),
      .fired     (fired[c])
    );
  end

  // Only the low channels show in the mask
  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < CHANNELS) begin : g_used
      assign fired_mask[b] = fired[b];
    end else begin : g_none
      assign fired_mask[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      counting <= 1'b1;
    end else if (step) begin
      count    <= count_next;
      counting <= counting_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_accepted <= accepted_next;
      out_fired    <= fired_mask;
      out_count    <= count_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.accepted      = out_accepted;
  assign rsp.fired_mask    = out_fired;
  assign rsp.current_count = out_count;

  // A command other than tick never reports a firing channel
  a_fire_only_tick: assert property (@(posedge clk) disable iff (rst)
    !rst && step && in_command != CMD_TICK |=> out_fired == '0)
    else $error("fired mask set for a non-tick command");

  // The counter moves by at most one per command
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !rst && step |=> (count == $past(count)) || (count == $past(count) + 1'b1))
    else $error("counter jumped");

  // A stopped counter holds its value
  a_stopped_holds: assert property (@(posedge clk) disable iff (rst)
    !rst && step && !counting |=> count == $past(count))
    else $error("counter moved while stopped");

endmodule
